@@ hdl/kms_pkg.sv @@
// Package: shared constants, types and register indexes for the keypad scanner.
`timescale 1ns / 1ps
`default_nettype none
package kms_pkg;

    // Matrix geometry
    localparam int ROWS   = 5;
    localparam int COLS   = 5;
    localparam int PIN_W  = 5;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int COL_EXT = 1 << COL_W;

    localparam int CNT_W  = 4;
    localparam int POS_W  = 8;
    localparam int CFG_W  = 4;

    localparam logic [CNT_W-1:0] CNT_MAX          = '1;
    localparam logic [POS_W-1:0] NONE_POS         = 8'd255;
    localparam logic [PIN_W-1:0] PIN_MASK         = '1;
    localparam logic [CFG_W-1:0] SETTLE_RESET     = 4'd2;
    localparam logic [CFG_W-1:0] THRESHOLD_RESET  = 4'd3;

    // Configuration register indexes
    localparam logic CFG_SETTLE_TICKS    = 1'b0;
    localparam logic CFG_PRESS_THRESHOLD = 1'b1;

    // Request kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_ROW_SET  = 4'b0010,
        PH_SCAN     = 4'b0100,
        PH_DEBOUNCE = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] settle_ticks;
        logic [CFG_W-1:0] press_threshold;
    } cfg_t;

    typedef struct packed {
        logic [PIN_W-1:0] row_drive;
        logic             key_ready;
        logic [POS_W-1:0] key_row;
        logic [POS_W-1:0] key_col;
        logic             scanning_halted;
    } result_t;

endpackage
`default_nettype wire

@@ hdl/keypad_matrix_scanner.sv @@
// Top level: request register, configuration registers, scan core, result register.
`timescale 1ns / 1ps
`default_nettype none
// Keypad matrix scanner. Each request is a scan tick or a clear of the key
// report, and each produces exactly one result with the row pin levels, the
// ready flag, the latched key position (255 when none) and the halt flag.
// One request is taken every cycle while s_ready is high; a request waits in
// the input register, and the scan state machine updates as it moves into the
// result register, which then presents the result.
// While a result waits, one more request is held in the input register; after
// that s_ready stays low until the result is taken. Configuration writes
// (settle_ticks at index 0, press_threshold at index 1) take effect at once
// and belong in idle periods.
module keypad_matrix_scanner (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_kind,
    input  wire logic [kms_pkg::PIN_W-1:0]  s_column_levels,

    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [kms_pkg::PIN_W-1:0]       m_row_drive,
    output logic                            m_key_ready,
    output logic [kms_pkg::POS_W-1:0]       m_key_row,
    output logic [kms_pkg::POS_W-1:0]       m_key_col,
    output logic                            m_scanning_halted,

    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [kms_pkg::CFG_W-1:0]  cfg_data
);
    import kms_pkg::*;

    cfg_t             cfg_reg;
    logic             in_valid_reg;
    logic             in_kind_reg;
    logic [PIN_W-1:0] in_levels_reg;
    logic             out_valid_reg;
    result_t          out_reg;
    result_t          core_result;
    logic             advance;
    logic             s_fire;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_ticks    <= SETTLE_RESET;
            cfg_reg.press_threshold <= THRESHOLD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SETTLE_TICKS:    cfg_reg.settle_ticks    <= cfg_data;
                CFG_PRESS_THRESHOLD: cfg_reg.press_threshold <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_kind_reg   <= s_kind;
            in_levels_reg <= s_column_levels;
        end
    end

    kms_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .kind    (in_kind_reg),
        .levels  (in_levels_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_row_drive       = out_reg.row_drive;
    assign m_key_ready       = out_reg.key_ready;
    assign m_key_row         = out_reg.key_row;
    assign m_key_col         = out_reg.key_col;
    assign m_scanning_halted = out_reg.scanning_halted;

`ifndef SYNTHESIS
    a_halt_implies_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_scanning_halted |-> m_key_ready)
        else $error("halt reported without key ready");

    a_ready_has_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_key_ready |-> m_key_row != NONE_POS && m_key_col != NONE_POS)
        else $error("key ready without a latched position");

    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled with room downstream");

    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("request advanced but no result");
`endif

endmodule
`default_nettype wire

@@ hdl/kms_col_pick.sv @@
// Column decode: pressed mask from active-low levels and lowest pressed column.
`timescale 1ns / 1ps
`default_nettype none
module kms_col_pick (
    input  wire logic [kms_pkg::PIN_W-1:0]   levels,
    output logic                             found,
    output logic [kms_pkg::COL_W-1:0]        col_idx,
    output logic [kms_pkg::COL_EXT-1:0]      pressed
);
    import kms_pkg::*;

    always_comb begin
        pressed = '0;
        for (int c = 0; c < COLS; c++) begin
            if (c < PIN_W) begin
                pressed[c] = !levels[c];
            end
        end
    end

    // Walk down so the lowest pressed column wins
    always_comb begin
        found   = 1'b0;
        col_idx = '0;
        for (int c = COLS - 1; c >= 0; c--) begin
            if (pressed[c]) begin
                found   = 1'b1;
                col_idx = COL_W'(c);
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/kms_core.sv @@
// Scan state machine: row drive, settle and debounce counters, key latch.
`timescale 1ns / 1ps
`default_nettype none
module kms_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       step,
    input  wire logic                       kind,
    input  wire logic [kms_pkg::PIN_W-1:0]  levels,
    input  wire kms_pkg::cfg_t              cfg,
    output kms_pkg::result_t                result
);
    import kms_pkg::*;

    phase_t             phase_reg,    phase_next;
    logic [ROW_W-1:0]   scan_row_reg, scan_row_next;
    logic [PIN_W-1:0]   row_pins_reg, row_pins_next;
    logic [CNT_W-1:0]   settle_reg,   settle_next;
    logic [CNT_W-1:0]   deb_reg,      deb_next;
    logic               reported_reg, reported_next;
    logic               ready_reg,    ready_next;
    logic               latched_reg,  latched_next;
    logic [ROW_W-1:0]   lat_row_reg,  lat_row_next;
    logic [COL_W-1:0]   lat_col_reg,  lat_col_next;
    logic               halted_reg,   halted_next;

    logic               found;
    logic [COL_W-1:0]   col_idx;
    logic [COL_EXT-1:0] pressed;
    logic [CNT_W-1:0]   settle_inc;
    logic [CNT_W-1:0]   deb_inc;
    logic               held;
    logic [PIN_W-1:0]   drive_pins;

    kms_col_pick u_pick (
        .levels  (levels),
        .found   (found),
        .col_idx (col_idx),
        .pressed (pressed)
    );

    assign settle_inc = (settle_reg == CNT_MAX) ? settle_reg : settle_reg + 1'b1;
    assign deb_inc    = (deb_reg == CNT_MAX) ? deb_reg : deb_reg + 1'b1;
    // An empty latch never reads as pressed
    assign held       = latched_reg && pressed[lat_col_reg];

    always_comb begin
        for (int i = 0; i < PIN_W; i++) begin
            drive_pins[i] = !(int'(scan_row_reg) == i);
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        scan_row_next = scan_row_reg;
        row_pins_next = row_pins_reg;
        settle_next   = settle_reg;
        deb_next      = deb_reg;
        reported_next = reported_reg;
        ready_next    = ready_reg;
        latched_next  = latched_reg;
        lat_row_next  = lat_row_reg;
        lat_col_next  = lat_col_reg;
        halted_next   = halted_reg;

        if (kind == KIND_CLEAR) begin
            ready_next   = 1'b0;
            latched_next = 1'b0;
            halted_next  = 1'b0;
        end else if (!halted_reg) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    row_pins_next = drive_pins;
                    settle_next   = '0;
                    phase_next    = PH_ROW_SET;
                end
                PH_ROW_SET: begin
                    settle_next = settle_inc;
                    if (settle_inc >= cfg.settle_ticks) begin
                        phase_next = PH_SCAN;
                    end
                end
                PH_SCAN: begin
                    if (found) begin
                        latched_next = 1'b1;
                        lat_row_next = scan_row_reg;
                        lat_col_next = col_idx;
                        deb_next     = '0;
                        phase_next   = PH_DEBOUNCE;
                    end else begin
                        scan_row_next = (int'(scan_row_reg) == ROWS - 1) ?
                                        '0 : scan_row_reg + 1'b1;
                        phase_next    = PH_IDLE;
                    end
                end
                PH_DEBOUNCE: begin
                    if (held) begin
                        if (!reported_reg) begin
                            deb_next = deb_inc;
                            if (deb_inc >= cfg.press_threshold) begin
                                ready_next    = 1'b1;
                                reported_next = 1'b1;
                                halted_next   = 1'b1;
                                phase_next    = PH_IDLE;
                            end
                        end
                    end else begin
                        latched_next  = 1'b0;
                        deb_next      = '0;
                        reported_next = 1'b0;
                        phase_next    = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            scan_row_reg <= '0;
            row_pins_reg <= PIN_MASK;
            settle_reg   <= '0;
            deb_reg      <= '0;
            reported_reg <= 1'b0;
            ready_reg    <= 1'b0;
            latched_reg  <= 1'b0;
            lat_row_reg  <= '0;
            lat_col_reg  <= '0;
            halted_reg   <= 1'b0;
        end else if (step) begin
            phase_reg    <= phase_next;
            scan_row_reg <= scan_row_next;
            row_pins_reg <= row_pins_next;
            settle_reg   <= settle_next;
            deb_reg      <= deb_next;
            reported_reg <= reported_next;
            ready_reg    <= ready_next;
            latched_reg  <= latched_next;
            lat_row_reg  <= lat_row_next;
            lat_col_reg  <= lat_col_next;
            halted_reg   <= halted_next;
        end
    end

    // Result reflects the state after this request
    always_comb begin
        result.row_drive       = row_pins_next;
        result.key_ready       = ready_next;
        result.key_row         = latched_next ? POS_W'(lat_row_next) : NONE_POS;
        result.key_col         = latched_next ? POS_W'(lat_col_next) : NONE_POS;
        result.scanning_halted = halted_next;
    end

`ifndef SYNTHESIS
    // A halt always comes with a pending report
    a_halt_has_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> ready_reg && latched_reg)
        else $error("halted without a latched ready key");

    // Ticks during a halt leave the scan untouched
    a_halt_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        step && kind == KIND_TICK && halted_reg |=>
            $stable(phase_reg) && $stable(scan_row_reg) && $stable(row_pins_reg))
        else $error("scan moved while halted");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_row_reg < ROW_W'(ROWS))
        else $error("scan row out of range");
`endif

endmodule
`default_nettype wire
